/* sv/cgo_pkg.sv */
// Package for the central-gravity orbit stepper: types, codes, constants and the
// saturating fixed-point helpers shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package cgo_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_BODIES_DEF = 2;
    localparam int FRAC_BITS_DEF  = 32;

    // Fixed field widths
    localparam int VAL_W   = 64;
    localparam int CFG_W   = 2;
    localparam int IN_W    = 4 * VAL_W;
    localparam int OUT_W   = 5 * VAL_W;
    localparam int DEN_W   = 3 * VAL_W;

    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_NEG = 64'h8000_0000_0000_0000;

    // Opcodes of an input item
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        REG_GRAVITY   = 2'd0,
        REG_TIME_STEP = 2'd1,
        REG_CENTER_X  = 2'd2,
        REG_CENTER_Y  = 2'd3
    } cfg_reg_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TIME,
        S_DIFF,
        S_GO,
        S_WAIT,
        S_OUT
    } ctrl_state_t;

    // Per-body work steps, in issue order
    typedef enum logic [3:0] {
        ST_DXX,   // dx^2
        ST_DYY,   // dy^2, summed into d2
        ST_SQRT,  // r = floor(sqrt(d2))
        ST_RR,    // r^2
        ST_RRR,   // r^3
        ST_GX,    // GM*|dx|
        ST_DIVX,  // ax
        ST_GY,    // GM*|dy|
        ST_DIVY,  // ay
        ST_AX,    // vx += ax*dt
        ST_AY,    // vy += ay*dt
        ST_VX,    // px += vx*dt
        ST_VY     // py += vy*dt
    } step_t;

    // Controller to datapath
    typedef struct packed {
        logic  load_we;
        logic  time_en;
        logic  diff_en;
        logic  body_inc;
        logic  go;
        logic  wb;
        step_t step;
    } cgo_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic root_zero;
        logic last_body;
    } cgo_status_t;

    function automatic step_t next_step(input step_t s);
        step_t n;
        unique case (s)
            ST_DXX:  n = ST_DYY;
            ST_DYY:  n = ST_SQRT;
            ST_SQRT: n = ST_RR;
            ST_RR:   n = ST_RRR;
            ST_RRR:  n = ST_GX;
            ST_GX:   n = ST_DIVX;
            ST_DIVX: n = ST_GY;
            ST_GY:   n = ST_DIVY;
            ST_DIVY: n = ST_AX;
            ST_AX:   n = ST_AY;
            ST_AY:   n = ST_VX;
            ST_VX:   n = ST_VY;
            default: n = ST_VY;
        endcase
        return n;
    endfunction

    // Magnitude of a two's complement value (most negative gives 2^63)
    function automatic logic [63:0] mag_of(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // Returns {overflow, value}
    function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        logic        ov;
        s  = a + b;
        ov = (a[63] == b[63]) && (s[63] != a[63]);
        return ov ? {1'b1, (a[63] ? MAX_NEG : MAX_POS)} : {1'b0, s};
    endfunction

    function automatic logic [64:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] d;
        logic        ov;
        d  = a - b;
        ov = (a[63] != b[63]) && (d[63] != a[63]);
        return ov ? {1'b1, (a[63] ? MAX_NEG : MAX_POS)} : {1'b0, d};
    endfunction

    // Sign plus magnitude to saturated signed value; returns {overflow, value}
    function automatic logic [64:0] sat_signed(input logic neg, input logic [63:0] mag,
                                               input logic big);
        logic [64:0] r;
        if (!neg) begin
            r = (big || mag[63]) ? {1'b1, MAX_POS} : {1'b0, mag};
        end
        else begin
            r = (big || (mag > MAX_NEG)) ? {1'b1, MAX_NEG} : {1'b0, ~mag + 64'd1};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cgo_mul.sv */
// Sequential 128 x 64 bit unsigned multiplier built on one 32 x 32 multiplier.
// Eight partial products, one per cycle, each accumulated in the cycle after it is formed.
// Depends on cgo_pkg.
`default_nettype none

module cgo_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [127:0]                a,
    input  wire logic [63:0]                 b,
    output logic      [cgo_pkg::DEN_W-1:0]   prod,
    output logic                             done
);
    import cgo_pkg::*;

    logic [127:0]      a_reg;
    logic [63:0]       b_reg;
    logic [3:0]        cnt_reg;
    logic              busy_reg;
    logic              pv_reg;
    logic [2:0]        sh_reg;
    logic [63:0]       pp_reg;
    logic [DEN_W-1:0]  acc_reg;
    logic              done_reg;

    // Partial product and its word offset
    logic [63:0] pp_next;
    logic [2:0]  sh_next;
    always_comb
    begin
        pp_next = 64'(a_reg[{cnt_reg[2:1], 5'b0} +: 32]) * 64'(b_reg[{cnt_reg[0], 5'b0} +: 32]);
        sh_next = {1'b0, cnt_reg[2:1]} + {2'b0, cnt_reg[0]};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                pv_reg   <= 1'b0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                pv_reg  <= !cnt_reg[3];
                if (cnt_reg[3]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg) begin
            pp_reg <= pp_next;
            sh_reg <= sh_next;
            if (pv_reg) begin
                acc_reg <= acc_reg + (DEN_W'(pp_reg) << {sh_reg, 5'b0});
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/cgo_sqrt.sv */
// Digit-by-digit integer square root of a 128-bit value, one result bit per cycle.
// Depends on cgo_pkg.
`default_nettype none

module cgo_sqrt (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] radicand,
    output logic      [63:0]  root,
    output logic              done
);
    import cgo_pkg::*;

    logic [127:0] rad_reg;
    logic [67:0]  rem_reg;
    logic [63:0]  root_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    // One trial subtraction
    logic [67:0] rem_sh;
    logic [67:0] trial;
    logic        ge;
    always_comb
    begin
        rem_sh = {rem_reg[65:0], rad_reg[127:126]};
        trial  = {2'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg) begin
            rad_reg  <= {rad_reg[125:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[62:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/cgo_div.sv */
// Restoring divider for the acceleration: NUM_W-bit numerator by 192-bit
// denominator, 64 quotient bits one per cycle, plus an up-front overflow test.
// Depends on cgo_pkg.
`default_nettype none

module cgo_div #(
    parameter int NUM_W = 190
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [NUM_W-1:0]           num,
    input  wire logic [cgo_pkg::DEN_W-1:0]  den,
    output logic      [63:0]                quot,
    output logic                            over,
    output logic                            done
);
    import cgo_pkg::*;

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [63:0]      low_reg;
    logic [63:0]      q_reg;
    logic             over_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // High part of the numerator; quotient fits 64 bits only if it is below den
    logic [DEN_W-1:0] num_hi;
    logic [DEN_W:0]   t;
    logic             ge;
    logic [DEN_W:0]   diff;
    always_comb
    begin
        num_hi = DEN_W'(num[NUM_W-1:64]);
        t      = {rem_reg, low_reg[63]};
        ge     = t >= {1'b0, den_reg};
        diff   = t - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            den_reg  <= den;
            rem_reg  <= num_hi;
            low_reg  <= num[63:0];
            q_reg    <= '0;
            over_reg <= num_hi >= den;
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
            low_reg <= {low_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    assign quot = q_reg;
    assign over = over_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* sv/cgo_ctrl.sv */
// Controller of the orbit stepper: accepts items, sequences the per-body work
// steps and hands results out. Depends on cgo_pkg.
`default_nettype none

module cgo_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_opcode,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire cgo_pkg::cgo_status_t status,
    output cgo_pkg::cgo_cmd_t         cmd
);
    import cgo_pkg::*;

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= ST_DXX;
        end
        else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_opcode == OP_LOAD) begin
                        cmd.load_we = 1'b1;
                    end
                    else begin
                        state_next = S_TIME;
                    end
                end
            end
            S_TIME: begin
                cmd.time_en = 1'b1;
                state_next  = S_DIFF;
            end
            S_DIFF: begin
                cmd.diff_en = 1'b1;
                step_next   = ST_DXX;
                state_next  = S_GO;
            end
            S_GO: begin
                cmd.go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (status.done) begin
                    cmd.wb = 1'b1;
                    priority if (step_reg == ST_VY) begin
                        state_next = S_OUT;
                    end
                    else if (step_reg == ST_SQRT && status.root_zero) begin
                        // zero distance: no acceleration, go straight to velocity
                        step_next  = ST_AX;
                        state_next = S_GO;
                    end
                    else begin
                        step_next  = next_step(step_reg);
                        state_next = S_GO;
                    end
                end
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (status.last_body) begin
                        state_next = S_IDLE;
                    end
                    else begin
                        cmd.body_inc = 1'b1;
                        state_next   = S_DIFF;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_go_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GO |=> state_reg == S_WAIT)
        else $error("unit start not followed by wait");
    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && !status.done) |=> (state_reg == S_WAIT && $stable(step_reg)))
        else $error("left wait without unit completion");
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_ready && status.last_body) |=> state_reg == S_IDLE)
        else $error("tick did not end after last body");
`endif

endmodule

`default_nettype wire

/* sv/cgo_dpath.sv */
// Datapath of the orbit stepper: configuration and body state registers, the
// shared multiplier, square root and divider, and the saturating writeback.
// Depends on cgo_pkg, cgo_mul, cgo_sqrt, cgo_div.
`default_nettype none

module cgo_dpath #(
    parameter int NUM_BODIES = cgo_pkg::NUM_BODIES_DEF,
    parameter int FRAC_BITS  = cgo_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cgo_pkg::cgo_cmd_t           cmd,
    output cgo_pkg::cgo_status_t             status,
    input  wire logic                        cfg_we,
    input  wire logic [cgo_pkg::CFG_W-1:0]   cfg_index,
    input  wire logic [63:0]                 cfg_data,
    input  wire logic [cgo_pkg::IN_W-1:0]    in_data,
    input  wire logic                        in_select,
    output logic      [cgo_pkg::OUT_W-1:0]   out_data,
    output logic      [2:0]                  out_user,
    output logic                             out_last
);
    import cgo_pkg::*;

    localparam int BW    = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam int NUM_W = 126 + 2 * FRAC_BITS;

    // Configuration
    logic [62:0] gm_reg, dt_reg;
    logic [63:0] cx_reg, cy_reg;

    // Body state
    logic [63:0] pos_x_reg [NUM_BODIES];
    logic [63:0] pos_y_reg [NUM_BODIES];
    logic [63:0] vel_x_reg [NUM_BODIES];
    logic [63:0] vel_y_reg [NUM_BODIES];
    logic [62:0] elapsed_reg;
    logic        tsat_reg;
    logic [BW-1:0] body_reg;

    // Per-body work registers
    logic              sat_reg, sing_reg;
    logic [63:0]       dx_reg, dy_reg, ax_reg, ay_reg, r_reg;
    logic [127:0]      d2_reg, rr_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;

    // Units
    logic              mul_start, sqrt_start, div_start;
    logic [127:0]      mul_a;
    logic [63:0]       mul_b;
    logic [DEN_W-1:0]  mul_p;
    logic              mul_done, sqrt_done, div_done;
    logic [63:0]       sqrt_root, div_q;
    logic              div_over;

    cgo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .done  (mul_done)
    );

    cgo_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (d2_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    cgo_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (div_q),
        .over  (div_over),
        .done  (div_done)
    );

    // Current body's state
    logic [63:0] cur_px, cur_py, cur_vx, cur_vy;
    always_comb
    begin
        cur_px = pos_x_reg[body_reg];
        cur_py = pos_y_reg[body_reg];
        cur_vx = vel_x_reg[body_reg];
        cur_vy = vel_y_reg[body_reg];
    end

    // Operand selection, unit starts and status
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        status.done = 1'b0;
        status.root_zero = (sqrt_root == 64'd0);
        status.last_body = (32'(body_reg) == NUM_BODIES - 1);
        unique case (cmd.step)
            ST_DXX: begin
                mul_a = 128'(mag_of(dx_reg));
                mul_b = mag_of(dx_reg);
            end
            ST_DYY: begin
                mul_a = 128'(mag_of(dy_reg));
                mul_b = mag_of(dy_reg);
            end
            ST_RR: begin
                mul_a = 128'(r_reg);
                mul_b = r_reg;
            end
            ST_RRR: begin
                mul_a = rr_reg;
                mul_b = r_reg;
            end
            ST_GX: begin
                mul_a = 128'(gm_reg);
                mul_b = mag_of(dx_reg);
            end
            ST_GY: begin
                mul_a = 128'(gm_reg);
                mul_b = mag_of(dy_reg);
            end
            ST_AX: begin
                mul_a = 128'(mag_of(ax_reg));
                mul_b = 64'(dt_reg);
            end
            ST_AY: begin
                mul_a = 128'(mag_of(ay_reg));
                mul_b = 64'(dt_reg);
            end
            ST_VX: begin
                mul_a = 128'(mag_of(cur_vx));
                mul_b = 64'(dt_reg);
            end
            ST_VY: begin
                mul_a = 128'(mag_of(cur_vy));
                mul_b = 64'(dt_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        if (cmd.step == ST_SQRT) begin
            sqrt_start  = cmd.go;
            status.done = sqrt_done;
        end
        else if (cmd.step == ST_DIVX || cmd.step == ST_DIVY) begin
            div_start   = cmd.go;
            status.done = div_done;
        end
        else begin
            mul_start   = cmd.go;
            status.done = mul_done;
        end
    end

    // Saturated quotient for the acceleration
    logic [64:0] acc_res;
    assign acc_res = sat_signed((cmd.step == ST_DIVX) ? dx_reg[63] : dy_reg[63],
                                div_q, div_over);

    // Product with dt, truncated toward zero, then added to its target
    logic        sc_neg;
    logic [63:0] sc_target;
    logic [64:0] sc_val, sum_val;
    always_comb
    begin
        unique case (cmd.step)
            ST_AX:   begin sc_neg = ax_reg[63]; sc_target = cur_vx; end
            ST_AY:   begin sc_neg = ay_reg[63]; sc_target = cur_vy; end
            ST_VX:   begin sc_neg = cur_vx[63]; sc_target = cur_px; end
            ST_VY:   begin sc_neg = cur_vy[63]; sc_target = cur_py; end
            default: begin sc_neg = 1'b0;       sc_target = '0;     end
        endcase
        sc_val  = sat_signed(sc_neg, mul_p[FRAC_BITS+63:FRAC_BITS],
                             |mul_p[DEN_W-1:FRAC_BITS+64]);
        sum_val = add_sat(sc_target, sc_val[63:0]);
    end

    // Time step and distance
    logic [63:0] time_sum;
    logic [64:0] dx_next, dy_next;
    logic        ld_ok;
    assign time_sum = {1'b0, elapsed_reg} + {1'b0, dt_reg};
    assign dx_next  = sub_sat(cx_reg, cur_px);
    assign dy_next  = sub_sat(cy_reg, cur_py);
    assign ld_ok    = (32'(in_select) < NUM_BODIES);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gm_reg <= '0;
            dt_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GRAVITY:   gm_reg <= cfg_data[62:0];
                REG_TIME_STEP: dt_reg <= cfg_data[62:0];
                REG_CENTER_X:  cx_reg <= cfg_data;
                REG_CENTER_Y:  cy_reg <= cfg_data;
                default:       gm_reg <= gm_reg;
            endcase
        end
    end

    // Body state, time and body counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_BODIES; i++) begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
                vel_x_reg[i] <= '0;
                vel_y_reg[i] <= '0;
            end
            elapsed_reg <= '0;
            tsat_reg    <= 1'b0;
            body_reg    <= '0;
        end
        else begin
            if (cmd.load_we && ld_ok) begin
                pos_x_reg[BW'(in_select)] <= in_data[63:0];
                pos_y_reg[BW'(in_select)] <= in_data[127:64];
                vel_x_reg[BW'(in_select)] <= in_data[191:128];
                vel_y_reg[BW'(in_select)] <= in_data[255:192];
            end
            if (cmd.time_en) begin
                elapsed_reg <= time_sum[63] ? MAX_POS[62:0] : time_sum[62:0];
                tsat_reg    <= time_sum[63];
                body_reg    <= '0;
            end
            if (cmd.body_inc) begin
                body_reg <= body_reg + BW'(1);
            end
            if (cmd.wb) begin
                unique case (cmd.step)
                    ST_AX:   vel_x_reg[body_reg] <= sum_val[63:0];
                    ST_AY:   vel_y_reg[body_reg] <= sum_val[63:0];
                    ST_VX:   pos_x_reg[body_reg] <= sum_val[63:0];
                    ST_VY:   pos_y_reg[body_reg] <= sum_val[63:0];
                    default: tsat_reg            <= tsat_reg;
                endcase
            end
        end
    end

    // Per-body work registers and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sat_reg  <= 1'b0;
            sing_reg <= 1'b0;
        end
        else if (cmd.diff_en) begin
            sat_reg  <= tsat_reg | dx_next[64] | dy_next[64];
            sing_reg <= 1'b0;
        end
        else if (cmd.wb) begin
            unique case (cmd.step)
                ST_SQRT:                    sing_reg <= status.root_zero;
                ST_DIVX, ST_DIVY:           sat_reg  <= sat_reg | acc_res[64];
                ST_AX, ST_AY, ST_VX, ST_VY: sat_reg  <= sat_reg | sc_val[64] | sum_val[64];
                default:                    sat_reg  <= sat_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff_en) begin
            dx_reg <= dx_next[63:0];
            dy_reg <= dy_next[63:0];
            ax_reg <= '0;
            ay_reg <= '0;
        end
        else if (cmd.wb) begin
            unique case (cmd.step)
                ST_DXX:  d2_reg  <= mul_p[127:0];
                ST_DYY:  d2_reg  <= d2_reg + mul_p[127:0];
                ST_SQRT: r_reg   <= sqrt_root;
                ST_RR:   rr_reg  <= mul_p[127:0];
                ST_RRR:  den_reg <= mul_p;
                ST_GX:   num_reg <= NUM_W'(mul_p[125:0]) << (2 * FRAC_BITS);
                ST_GY:   num_reg <= NUM_W'(mul_p[125:0]) << (2 * FRAC_BITS);
                ST_DIVX: ax_reg  <= acc_res[63:0];
                ST_DIVY: ay_reg  <= acc_res[63:0];
                default: r_reg   <= r_reg;
            endcase
        end
    end

    // Result fields
    assign out_data = {1'b0, elapsed_reg, cur_vy, cur_vx, cur_py, cur_px};
    assign out_user = {sat_reg, sing_reg, body_reg[0]};
    assign out_last = status.last_body;

endmodule

`default_nettype wire

/* sv/central_gravity_orbit_step.sv */
// Orbit stepper for bodies around a fixed central mass (semi-implicit Euler).
// Top level: ties the controller to the datapath. Depends on cgo_pkg, cgo_ctrl,
// cgo_dpath.
//
// Usage:
//  - cfg channel writes GM, dt and the center position (index 0..3); it is
//    always ready and must be written only while the block is idle (unchecked).
//  - Slave stream: tuser selects load or tick. A load writes one body's
//    position and velocity and produces no output.
//  - A tick adds dt to the simulated time, then steps every body in index
//    order and sends one result per body on the master stream, tlast on the
//    final body.
//  - Per body: ten 128x64 multiplies on one 32x32 multiplier, a square root
//    and two divisions, after a distance step and before the result; when
//    the distance is zero, the r^2, r^3 and GM multiplies and both divisions
//    are skipped.
//  - One item at a time: s_tready is high only while idle. A result waits in
//    place while m_tready is low and the next body starts after its transfer.
//  - Reset clears the configuration registers, all body state and the simulated time.
`default_nettype none

module central_gravity_orbit_step #(
    parameter int NUM_BODIES = cgo_pkg::NUM_BODIES_DEF,
    parameter int FRAC_BITS  = cgo_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [cgo_pkg::CFG_W-1:0]  cfg_index,
    input  wire logic [63:0]                cfg_data,
    // input items
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [cgo_pkg::IN_W-1:0]   s_tdata,  // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  wire logic [1:0]                 s_tuser,  // opcode, body_select
    // results
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [cgo_pkg::OUT_W-1:0]  m_tdata,  // new_pos_x, new_pos_y, new_vel_x,
                                                      // new_vel_y, sim_time_out, zero pad
    output logic      [2:0]                 m_tuser,  // body_index, singular_flag, saturated_flag
    output logic                            m_tlast   // last_of_tick
);
    import cgo_pkg::*;

    cgo_cmd_t    cmd;
    cgo_status_t status;

    assign cfg_ready = 1'b1;

    cgo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    cgo_dpath #(
        .NUM_BODIES (NUM_BODIES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_select (s_tuser[1]),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after final result");
    a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == OP_TICK) |=> !m_tvalid)
        else $error("result too early after tick");
`endif

endmodule

`default_nettype wire
